>>> rtl/ctcs_pkg.sv
// ----------------------------------------------------------------------------
// ctcs_pkg
// Shared types and constants for the composite tile container splitter.
// ----------------------------------------------------------------------------
package ctcs_pkg;

  // Default width of the byte position counter and the buffer size register.
  localparam int POSITION_BITS_DEF = 32;

  // Result queue depth; a byte pushes at most two results.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic [31:0] CMPT_MAGIC      = 32'h7470_6D63; // "cmpt", first byte lowest
  localparam logic [31:0] CMPT_VERSION    = 32'd1;
  localparam logic [31:0] HDR_BYTES       = 32'd16;        // outer header, also first tile
  localparam logic [31:0] INNER_HDR_BYTES = 32'd12;
  localparam logic [31:0] FIRST_HDR_END   = HDR_BYTES + INNER_HDR_BYTES;

  typedef enum logic [2:0] {
    EV_TILE    = 3'd0,
    EV_SHORT   = 3'd1,
    EV_MAGIC   = 3'd2,
    EV_VERSION = 3'd3,
    EV_OVER    = 3'd4,
    EV_TRUNC   = 3'd5,
    EV_DONE    = 3'd6
  } event_t;

  typedef enum logic {
    PH_HEADER = 1'b0,
    PH_INNER  = 1'b1
  } phase_t;

  typedef struct packed {
    event_t      ev;
    logic [31:0] index;
    logic [31:0] offset;
    logic [31:0] length;
    logic [31:0] magic;
    logic        last;
  } result_t;

endpackage

>>> rtl/ctcs_in_if.sv
// ----------------------------------------------------------------------------
// ctcs_in_if
// Byte stream channel: one buffer byte per transfer.
// ----------------------------------------------------------------------------
interface ctcs_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        end_of_buffer;
  logic [31:0] buffer_size;

  modport source (output valid, output data_byte, output end_of_buffer,
                  output buffer_size, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer,
                  input buffer_size, output ready);
endinterface

>>> rtl/ctcs_out_if.sv
// ----------------------------------------------------------------------------
// ctcs_out_if
// Result channel: one tile record or status per transfer.
// ----------------------------------------------------------------------------
interface ctcs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [31:0] tile_index;
  logic [31:0] tile_offset;
  logic [31:0] tile_length;
  logic [31:0] tile_magic;
  logic        last_result;

  modport source (output valid, output event_res, output tile_index,
                  output tile_offset, output tile_length, output tile_magic,
                  output last_result, input ready);
  modport sink   (input valid, input event_res, input tile_index,
                  input tile_offset, input tile_length, input tile_magic,
                  input last_result, output ready);
endinterface

>>> rtl/composite_tile_container_splitter.sv
// ----------------------------------------------------------------------------
// composite_tile_container_splitter
// Byte-serial parser for composite ("cmpt") tile containers.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake    | payload
//  ----------+-----+--------------+--------------------------------------------
//  in_chan   | in  | valid/ready  | data_byte, end_of_buffer, buffer_size
//  out_chan  | out | valid/ready  | event_res, tile_index, tile_offset,
//            |     |              | tile_length, tile_magic, last_result
//
//  One byte is taken per cycle while the queue has room. Its parse state
//  update and its results are computed in the same cycle; results are
//  registered into a four-entry queue and shown on out_chan from its head.
//  A byte that ends a tile header may yield two results (tile + done/truncated);
//  the queue drains one per cycle while out_chan.ready is high.
//  in_chan.ready is high while the queue has room for two results, so inputs
//  keep flowing through brief output stalls.
//  Reset (rst_n low, synchronous) returns the parser to the container header
//  state and empties the queue; no clearing pass is needed.
//
// ----------------------------------------------------------------------------
module composite_tile_container_splitter #(
  parameter int POSITION_BITS = ctcs_pkg::POSITION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ctcs_in_if.sink    in_chan,
  ctcs_out_if.source out_chan
);
  import ctcs_pkg::*;

  logic       in_fire;
  logic       room;
  logic [1:0] res_cnt;
  logic [1:0] push_cnt;
  result_t    res0, res1;

  assign in_chan.ready = room;
  assign in_fire       = in_chan.valid && in_chan.ready;
  // results count only for a byte actually transferred
  assign push_cnt      = in_fire ? res_cnt : 2'd0;

  // header checks, inner header walk, terminal status
  ctcs_parser #(
    .POSITION_BITS (POSITION_BITS)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .data_byte     (in_chan.data_byte),
    .end_of_buffer (in_chan.end_of_buffer),
    .buffer_size   (in_chan.buffer_size),
    .res0          (res0),
    .res1          (res1),
    .res_cnt       (res_cnt)
  );

  // decouples result delivery from byte intake
  ctcs_out_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_cnt),
    .push0    (res0),
    .push1    (res1),
    .room     (room),
    .out_chan (out_chan)
  );

endmodule

>>> rtl/ctcs_parser.sv
// ----------------------------------------------------------------------------
// ctcs_parser
// Per-byte parse state and decode; yields up to two results per byte.
// ----------------------------------------------------------------------------
module ctcs_parser #(
  parameter int POSITION_BITS = ctcs_pkg::POSITION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [7:0]        data_byte,
  input  logic              end_of_buffer,
  input  logic [31:0]       buffer_size,
  output ctcs_pkg::result_t res0,
  output ctcs_pkg::result_t res1,
  output logic [1:0]        res_cnt
);
  import ctcs_pkg::*;

  localparam logic [31:0] POS_MASK = 32'hFFFF_FFFF >> (32 - POSITION_BITS);

  // outer header field slots
  localparam logic [1:0] FLD_MAGIC   = 2'd0;
  localparam logic [1:0] FLD_VERSION = 2'd1;
  localparam logic [1:0] FLD_LENGTH  = 2'd2;
  localparam logic [1:0] FLD_COUNT   = 2'd3;

  localparam logic [31:0] INNER_MAGIC_LAST = 32'd3;
  localparam logic [31:0] INNER_LEN_LAST   = 32'd11;

  function automatic logic [31:0] fold_byte(input logic [31:0] acc,
                                            input logic [7:0]  b,
                                            input logic [1:0]  k);
    logic [31:0] sh;
    sh = {24'd0, b} << {k, 3'b000};
    return (k == 2'd0) ? sh : (acc | sh);
  endfunction

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] avail_r, avail_nxt;
  phase_t                   phase_r, phase_nxt;
  logic [31:0]              fs_r, fs_nxt;
  logic [31:0]              cl_r, cl_nxt;
  logic [31:0]              dtc_r, dtc_nxt;
  logic [31:0]              nha_r, nha_nxt;
  logic [31:0]              tf_r, tf_nxt;
  logic [31:0]              mag_r, mag_nxt;
  logic                     fin_r, fin_nxt;

  // decode
  logic                     first;
  logic [31:0]              sz_sat;
  logic [POSITION_BITS-1:0] avail_cur;
  logic                     size_short;
  logic [31:0]              pos_ext;
  logic [31:0]              rel_pos;
  logic                     hdr_act, inr_act;
  logic [31:0]              fs_new;
  logic                     hdr_word;
  logic [1:0]               fld;
  logic                     magic_bad, ver_bad, len_over;
  logic                     hdr_end, hdr_done, hdr_trunc, hdr_inner, eob_short;
  logic                     inr_magic, inr_len;
  logic [32:0]              sum;
  logic [33:0]              sum12;
  logic                     len_bad, tile_evt;
  logic [31:0]              tf1;
  logic                     adv_done, adv_trunc;
  logic                     stays_inner, tail_trunc;
  logic [31:0]              tf_after, nha_after;

  // result build
  logic                     has_term;
  event_t                   term_ev;
  result_t                  term_res, tile_res;

  always_comb begin
    first      = !fin_r && (pos_r == '0);
    sz_sat     = (buffer_size > POS_MASK) ? POS_MASK : buffer_size;
    avail_cur  = first ? sz_sat[POSITION_BITS-1:0] : avail_r;
    size_short = first && (32'(avail_cur) < HDR_BYTES);
    pos_ext    = 32'(pos_r);
    rel_pos    = pos_ext - nha_r;

    hdr_act = !fin_r && !size_short && (phase_r == PH_HEADER);
    inr_act = !fin_r && (phase_r == PH_INNER) && (pos_ext >= nha_r);
    fs_new  = fold_byte(fs_r, data_byte, hdr_act ? pos_r[1:0] : rel_pos[1:0]);

    // outer header: positions 0..15 only
    hdr_word  = hdr_act && (pos_r[1:0] == 2'd3);
    fld       = pos_r[3:2];
    magic_bad = hdr_word && (fld == FLD_MAGIC) && (fs_new != CMPT_MAGIC);
    ver_bad   = hdr_word && (fld == FLD_VERSION) && (fs_new != CMPT_VERSION);
    len_over  = hdr_word && (fld == FLD_LENGTH) && (fs_new > 32'(avail_cur));
    hdr_end   = hdr_word && (fld == FLD_COUNT);
    hdr_done  = hdr_end && ((tf_r >= fs_new) || (HDR_BYTES >= cl_r));
    hdr_trunc = hdr_end && !hdr_done && (FIRST_HDR_END > cl_r);
    hdr_inner = hdr_end && !hdr_done && !hdr_trunc;
    eob_short = hdr_act && end_of_buffer && !magic_bad && !ver_bad && !len_over
                && !hdr_end;

    // inner headers
    inr_magic = inr_act && (rel_pos == INNER_MAGIC_LAST);
    inr_len   = inr_act && (rel_pos == INNER_LEN_LAST);
    sum       = {1'b0, nha_r} + {1'b0, fs_new};
    sum12     = {2'b00, nha_r} + {2'b00, fs_new} + {2'b00, INNER_HDR_BYTES};
    len_bad   = inr_len && ((fs_new < INNER_HDR_BYTES) || (sum > {1'b0, cl_r}));
    tile_evt  = inr_len && !len_bad;
    tf1       = tf_r + 32'd1;
    adv_done  = tile_evt && ((tf1 >= dtc_r) || (sum >= {1'b0, cl_r}));
    adv_trunc = tile_evt && !adv_done && (sum12 > {2'b00, cl_r});

    stays_inner = ((phase_r == PH_INNER) && !fin_r && !len_bad && !adv_done
                   && !adv_trunc) || hdr_inner;
    tail_trunc  = end_of_buffer && stays_inner;

    tf_after  = tile_evt ? tf1 : tf_r;
    nha_after = tile_evt ? sum[31:0] : (hdr_end ? HDR_BYTES : nha_r);
  end

  // phase
  always_comb begin
    phase_nxt = phase_r;
    if (end_of_buffer) begin
      phase_nxt = PH_HEADER;
    end else if (hdr_inner) begin
      phase_nxt = PH_INNER;
    end
  end

  // datapath next state
  always_comb begin
    if (end_of_buffer) begin
      pos_nxt   = '0;
      avail_nxt = '0;
      fs_nxt    = '0;
      cl_nxt    = '0;
      dtc_nxt   = '0;
      nha_nxt   = HDR_BYTES;
      tf_nxt    = '0;
      mag_nxt   = '0;
      fin_nxt   = 1'b0;
    end else begin
      pos_nxt   = (pos_r != '1) ? pos_r + 1'b1 : pos_r;
      avail_nxt = first ? avail_cur : avail_r;
      fs_nxt    = (hdr_act || inr_act) ? fs_new : fs_r;
      cl_nxt    = (hdr_word && (fld == FLD_LENGTH)) ? fs_new : cl_r;
      dtc_nxt   = hdr_end ? fs_new : dtc_r;
      nha_nxt   = nha_after;
      tf_nxt    = tf_after;
      mag_nxt   = inr_magic ? fs_new : mag_r;
      fin_nxt   = fin_r || has_term;
    end
  end

  // results
  always_comb begin
    has_term = 1'b1;
    term_ev  = EV_DONE;
    priority if (size_short || eob_short) begin
      term_ev = EV_SHORT;
    end else if (magic_bad) begin
      term_ev = EV_MAGIC;
    end else if (ver_bad) begin
      term_ev = EV_VERSION;
    end else if (len_over) begin
      term_ev = EV_OVER;
    end else if (hdr_done || adv_done) begin
      term_ev = EV_DONE;
    end else if (len_bad || hdr_trunc || adv_trunc || tail_trunc) begin
      term_ev = EV_TRUNC;
    end else begin
      has_term = 1'b0;
    end

    term_res.ev     = term_ev;
    term_res.index  = ((term_ev == EV_TRUNC) || (term_ev == EV_DONE)) ? tf_after : '0;
    term_res.offset = (term_ev == EV_TRUNC) ? nha_after : '0;
    term_res.length = len_bad ? fs_new : '0;
    term_res.magic  = '0;
    term_res.last   = 1'b1;

    tile_res.ev     = EV_TILE;
    tile_res.index  = tf_r;
    tile_res.offset = nha_r;
    tile_res.length = fs_new;
    tile_res.magic  = mag_r;
    tile_res.last   = !has_term;

    res0    = tile_evt ? tile_res : term_res;
    res1    = term_res;
    res_cnt = {1'b0, tile_evt} + {1'b0, has_term};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      avail_r <= '0;
      phase_r <= PH_HEADER;
      fs_r    <= '0;
      cl_r    <= '0;
      dtc_r   <= '0;
      nha_r   <= HDR_BYTES;
      tf_r    <= '0;
      mag_r   <= '0;
      fin_r   <= 1'b0;
    end else if (in_fire) begin
      pos_r   <= pos_nxt;
      avail_r <= avail_nxt;
      phase_r <= phase_nxt;
      fs_r    <= fs_nxt;
      cl_r    <= cl_nxt;
      dtc_r   <= dtc_nxt;
      nha_r   <= nha_nxt;
      tf_r    <= tf_nxt;
      mag_r   <= mag_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

>>> rtl/ctcs_out_queue.sv
// ----------------------------------------------------------------------------
// ctcs_out_queue
// Small result queue: pushes up to two records a cycle, pops one when out_chan takes it.
// ----------------------------------------------------------------------------
module ctcs_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_cnt,
  input  ctcs_pkg::result_t push0,
  input  ctcs_pkg::result_t push1,
  output logic              room,
  ctcs_out_if.source        out_chan
);
  import ctcs_pkg::*;

  localparam int CNT_BITS = QUEUE_PTR_BITS + 1;

  result_t                   ent_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_BITS-1:0]       cnt_r, cnt_nxt;
  logic                      pop;
  logic [QUEUE_PTR_BITS-1:0] wr_p1;
  result_t                   head;

  always_comb begin
    pop     = out_chan.valid && out_chan.ready;
    wr_p1   = wr_r + 1'b1;
    wr_nxt  = wr_r + QUEUE_PTR_BITS'(push_cnt);
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + CNT_BITS'(push_cnt) - CNT_BITS'(pop);
    // two free slots needed: one byte can yield two results
    room    = cnt_r <= CNT_BITS'(QUEUE_DEPTH - 2);
    head    = ent_r[rd_r];
  end

  assign out_chan.valid       = cnt_r != '0;
  assign out_chan.event_res   = head.ev;
  assign out_chan.tile_index  = head.index;
  assign out_chan.tile_offset = head.offset;
  assign out_chan.tile_length = head.length;
  assign out_chan.tile_magic  = head.magic;
  assign out_chan.last_result = head.last;

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      ent_r[wr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      ent_r[wr_p1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> dv/composite_tile_container_splitter_tb.sv
// ----------------------------------------------------------------------------
// composite_tile_container_splitter_tb
// Self-checking bench for the byte-serial cmpt container splitter. A short
// scripted set of buffers pins down the short, magic and version status
// codes. Randomized buffers follow, mostly well-formed containers with
// seeded corruptions. Every result is matched against an in-bench parser
// model, with random stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module composite_tile_container_splitter_tb;
  import ctcs_pkg::*;

  // Parser model configuration, mirrors the DUT default.
  localparam int          POS_BITS = POSITION_BITS_DEF;
  localparam logic [31:0] POS_MAX  = 32'hFFFF_FFFF >> (32 - POS_BITS);

  // Outer header word slots, in byte_pos >> 2 terms.
  localparam logic [31:0] WORD_MAGIC   = 32'd0;
  localparam logic [31:0] WORD_VERSION = 32'd1;
  localparam logic [31:0] WORD_LENGTH  = 32'd2;

  // Inner header byte offsets where the magic and the length are complete.
  localparam logic [31:0] INNER_MAGIC_END  = 32'd3;
  localparam logic [31:0] INNER_LENGTH_END = 32'd11;

  localparam int RANDOM_BYTES = 910;
  localparam int LONG_HOLD    = 300;   // output hold-off, in cycles
  localparam int STALL_LIMIT  = 2000;  // cycles with no transfer at all
  localparam int REPORT_MAX   = 10;

  logic clk = 1'b0;
  logic rst_n;

  ctcs_in_if  in_if ();
  ctcs_out_if out_if ();

  composite_tile_container_splitter u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scripted buffers. Rows with pinned set carry the status that the byte must
  // raise (its last result); the rest are covered by the parser model alone.
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic [7:0]  data;
    logic        eob;
    logic [31:0] size;
    logic        pinned;
    event_t      ev;
  } script_row_t;

  localparam int SCRIPT_ROWS = 17;

  script_row_t script_rows [SCRIPT_ROWS] = '{
    // one-byte buffer of size zero: too short at once
    '{8'hFF, 1'b1, 32'd0,          1'b1, EV_SHORT},
    // one under the header size
    '{8'h00, 1'b1, 32'd15,         1'b1, EV_SHORT},
    // largest size, buffer ends two bytes into the header
    '{8'h63, 1'b0, 32'hFFFF_FFFF,  1'b0, EV_TILE},
    '{8'h6D, 1'b1, 32'd0,          1'b1, EV_SHORT},
    // "cmpx": bad magic, then the trailing byte is ignored
    '{8'h63, 1'b0, 32'd16,         1'b0, EV_TILE},
    '{8'h6D, 1'b0, 32'd0,          1'b0, EV_TILE},
    '{8'h70, 1'b0, 32'd0,          1'b0, EV_TILE},
    '{8'h78, 1'b0, 32'd0,          1'b1, EV_MAGIC},
    '{8'h00, 1'b1, 32'd0,          1'b0, EV_TILE},
    // "cmpt" version 2; only the first byte's size counts
    '{8'h63, 1'b0, 32'd100,        1'b0, EV_TILE},
    '{8'h6D, 1'b0, 32'd0,          1'b0, EV_TILE},
    '{8'h70, 1'b0, 32'd3,          1'b0, EV_TILE},
    '{8'h74, 1'b0, 32'd0,          1'b0, EV_TILE},
    '{8'h02, 1'b0, 32'd0,          1'b0, EV_TILE},
    '{8'h00, 1'b0, 32'd0,          1'b0, EV_TILE},
    '{8'h00, 1'b0, 32'd0,          1'b0, EV_TILE},
    '{8'h00, 1'b1, 32'd0,          1'b1, EV_VERSION}
  };

  // --------------------------------------------------------------------------
  // Parser model state
  // --------------------------------------------------------------------------
  logic [31:0] byte_pos;
  phase_t      phase;
  logic [31:0] field;
  logic [31:0] cont_len;
  logic [31:0] tile_count;
  logic [31:0] avail;
  logic [31:0] next_hdr;
  logic [31:0] tiles_found;
  logic [31:0] inner_magic;
  logic        stopped;

  result_t     step_res [2];
  int          step_n;
  result_t     expected_records [$];

  // Bookkeeping
  int unsigned failures;
  int unsigned live_bytes;     // bytes that reached a parser still at work
  int unsigned sent_bytes;     // every byte transfer
  int unsigned buffers_seen;
  int unsigned records_checked;
  int unsigned input_stalls;
  int unsigned ev_count [7];

  // Side info travelling with each input transfer (scripted pin checks).
  logic   pin_on;
  event_t pin_ev;

  // Sink control, set by the stimulus process.
  bit hold_request;
  bit steady_sink;

  // Generated buffer, sent by send_stream.
  logic [7:0]  stream_bytes [$];
  logic [31:0] stream_size;

  function automatic void parse_reset();
    byte_pos    = '0;
    phase       = PH_HEADER;
    field       = '0;
    cont_len    = '0;
    tile_count  = '0;
    avail       = '0;
    next_hdr    = HDR_BYTES;
    tiles_found = '0;
    inner_magic = '0;
    stopped     = 1'b0;
  endfunction

  function automatic void note_result(event_t ev, logic [31:0] idx, logic [31:0] off,
                                      logic [31:0] len, logic [31:0] mag);
    result_t r;
    r.ev     = ev;
    r.index  = idx;
    r.offset = off;
    r.length = len;
    r.magic  = mag;
    r.last   = 1'b0;
    step_res[step_n] = r;
    step_n++;
  endfunction

  // Terminal status; tile count only rides along on done and truncated.
  function automatic void halt_buffer(event_t ev, logic [31:0] off, logic [31:0] len);
    note_result(ev, (ev == EV_TRUNC || ev == EV_DONE) ? tiles_found : 32'd0, off, len, 32'd0);
    stopped = 1'b1;
  endfunction

  // After the tile count or a tile length is known: done, overrun, or walk on.
  function automatic void pick_next_header();
    if (tiles_found >= tile_count || next_hdr >= cont_len)
      halt_buffer(EV_DONE, 32'd0, 32'd0);
    else if ({1'b0, next_hdr} + {1'b0, INNER_HDR_BYTES} > {1'b0, cont_len})
      halt_buffer(EV_TRUNC, next_hdr, 32'd0);
    else
      phase = PH_INNER;
  endfunction

  // One accepted byte: update the model and queue the results it causes.
  function automatic void split_byte(logic [7:0] b, logic eob, logic [31:0] size);
    logic [31:0] p;
    logic [31:0] d;
    logic [1:0]  k;
    p = byte_pos;
    step_n = 0;
    if (!stopped)
      live_bytes++;

    if (!stopped && p == 32'd0) begin
      avail = (size > POS_MAX) ? POS_MAX : size;
      if (avail < HDR_BYTES)
        halt_buffer(EV_SHORT, 32'd0, 32'd0);
    end

    if (!stopped && phase == PH_HEADER) begin
      k = p[1:0];
      field = (k == 2'd0) ? {24'd0, b} : (field | ({24'd0, b} << (8 * k)));
      if (k == 2'd3) begin
        case (p >> 2)
          WORD_MAGIC: begin
            if (field != CMPT_MAGIC)
              halt_buffer(EV_MAGIC, 32'd0, 32'd0);
          end
          WORD_VERSION: begin
            if (field != CMPT_VERSION)
              halt_buffer(EV_VERSION, 32'd0, 32'd0);
          end
          WORD_LENGTH: begin
            cont_len = field;
            if (field > avail)
              halt_buffer(EV_OVER, 32'd0, 32'd0);
          end
          default: begin
            tile_count = field;
            next_hdr   = HDR_BYTES;
            pick_next_header();
          end
        endcase
      end
      if (!stopped && eob && phase == PH_HEADER)
        halt_buffer(EV_SHORT, 32'd0, 32'd0);
    end else if (!stopped && p >= next_hdr) begin
      d = p - next_hdr;
      k = d[1:0];
      field = (k == 2'd0) ? {24'd0, b} : (field | ({24'd0, b} << (8 * k)));
      if (d == INNER_MAGIC_END) begin
        inner_magic = field;
      end else if (d == INNER_LENGTH_END) begin
        if (field < INNER_HDR_BYTES ||
            {1'b0, next_hdr} + {1'b0, field} > {1'b0, cont_len}) begin
          halt_buffer(EV_TRUNC, next_hdr, field);
        end else begin
          note_result(EV_TILE, tiles_found, next_hdr, field, inner_magic);
          tiles_found++;
          next_hdr += field;
          pick_next_header();
        end
      end
    end

    if (!stopped && eob && phase == PH_INNER)
      halt_buffer(EV_TRUNC, next_hdr, 32'd0);

    if (step_n > 0)
      step_res[step_n - 1].last = 1'b1;
    for (int i = 0; i < step_n; i++)
      expected_records.insert(expected_records.size(), step_res[i]);

    if (eob)
      parse_reset();
    else if (byte_pos < POS_MAX)
      byte_pos++;
  endfunction

  function automatic string fmt_record(result_t r);
    return $sformatf("ev=%0d idx=%0d off=%0d len=%0d magic=%08h last=%0b",
                     r.ev, r.index, r.offset, r.length, r.magic, r.last);
  endfunction

  function automatic void note_failure(string what);
    failures++;
    if (failures <= REPORT_MAX)
      $display("MISMATCH: %s", what);
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 65)
      return 0;
    else if (roll < 92)
      return $urandom_range(3, 1);
    else
      return $urandom_range(40, 8);
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: predict on every input transfer, check every output transfer.
  // Both sides sample at the rising edge, before the DUT's updates land.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    result_t got;
    result_t want;
    if (rst_n) begin
      if (in_if.valid && !in_if.ready)
        input_stalls++;

      if (in_if.valid && in_if.ready) begin
        sent_bytes++;
        split_byte(in_if.data_byte, in_if.end_of_buffer, in_if.buffer_size);
        if (in_if.end_of_buffer)
          buffers_seen++;
        if (pin_on && (step_n == 0 || step_res[step_n - 1].ev != pin_ev))
          note_failure($sformatf("scripted byte %02h should end on status %0d, model gave %0d",
                                 in_if.data_byte, pin_ev,
                                 (step_n == 0) ? -1 : int'(step_res[step_n - 1].ev)));
      end

      if (out_if.valid && out_if.ready) begin
        got.ev     = event_t'(out_if.event_res);
        got.index  = out_if.tile_index;
        got.offset = out_if.tile_offset;
        got.length = out_if.tile_length;
        got.magic  = out_if.tile_magic;
        got.last   = out_if.last_result;
        if (expected_records.size() == 0) begin
          note_failure($sformatf("unexpected result %s", fmt_record(got)));
        end else begin
          want = expected_records.pop_front();
          records_checked++;
          ev_count[int'(want.ev)]++;
          if (got.ev !== want.ev || got.index !== want.index || got.offset !== want.offset ||
              got.length !== want.length || got.magic !== want.magic ||
              got.last !== want.last)
            note_failure($sformatf("expected %s, got %s", fmt_record(want), fmt_record(got)));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: random stalls, or a long hold-off when asked for one.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    out_if.ready <= 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stall = steady_sink ? 0 : pick_gap();
        if (stall == 0) begin
          out_if.ready <= 1'b1;
          @(posedge clk);
        end else begin
          out_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run once nothing has moved for too long.
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    do begin
      @(posedge clk);
      if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end while (idle_cycles < STALL_LIMIT);
    $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
             idle_cycles, expected_records.size());
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offer one byte after an optional gap and hold it until it transfers.
  task automatic send_byte(logic [7:0] data, logic eob, logic [31:0] size,
                           int unsigned gap, logic pin, event_t pev);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.data_byte     <= data;
    in_if.end_of_buffer <= eob;
    in_if.buffer_size   <= size;
    pin_on              <= pin;
    pin_ev              <= pev;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Sender goes quiet until every predicted result has come out.
  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_records.size() != 0) @(posedge clk);
  endtask

  task automatic add_word(logic [31:0] w);
    for (int i = 0; i < 4; i++)
      stream_bytes.insert(stream_bytes.size(), w[8 * i +: 8]);
  endtask

  // Builds one buffer: mostly a well-formed container with one corruption
  // picked at random, sometimes plain noise.
  task automatic build_stream();
    int unsigned ntiles;
    int unsigned flavor;
    int unsigned victim;
    int unsigned cut;
    logic [31:0] lens [$];
    int unsigned bodies [$];
    logic [31:0] len;
    logic [31:0] clen;
    logic [31:0] count;
    stream_bytes.delete();

    if ($urandom_range(99, 0) < 8) begin
      repeat ($urandom_range(24, 1))
        stream_bytes.insert(stream_bytes.size(), 8'($urandom));
      stream_size = $urandom_range(1, 0) ? $urandom : $urandom_range(15, 0);
    end else begin
      ntiles = $urandom_range(4, 0);
      clen   = HDR_BYTES;
      for (int i = 0; i < ntiles; i++) begin
        // mostly small tiles so the walk reaches many headers
        len = ($urandom_range(19, 0) == 0) ? $urandom_range(120, 25) : $urandom_range(20, 12);
        lens.insert(lens.size(), len);
        bodies.insert(bodies.size(), len - INNER_HDR_BYTES);
        clen += len;
      end
      count       = ntiles;
      stream_size = clen + $urandom_range(3, 0);
      victim      = (ntiles > 0) ? $urandom_range(ntiles - 1, 0) : 0;
      flavor      = $urandom_range(11, 0);

      case (flavor)
        0: count = $urandom_range(ntiles, 0);        // count runs out first
        1: begin                                     // next header would pass the end
          count = ntiles + $urandom_range(3, 1);
          clen += $urandom_range(11, 1);
          stream_size = clen;
        end
        2: if (ntiles > 0) lens[victim] = $urandom_range(11, 0);  // under twelve
        3: if (ntiles > 0) lens[victim] = $urandom;                // wild length
        4: if (ntiles > 0) clen -= $urandom_range(8, 1);          // last tile overruns
        7: begin                                     // size below declared length
          if (clen > HDR_BYTES && $urandom_range(1, 0))
            stream_size = $urandom_range(clen - 1, HDR_BYTES);
          else
            stream_size = $urandom_range(15, 0);
        end
        8: begin                                     // huge length and count
          count = $urandom;
          clen = $urandom_range(32'hFFFF_FFFF, clen);
          stream_size = $urandom_range(32'hFFFF_FFFF, clen);
        end
        9: stream_size = $urandom_range(32'hFFFF_FFFF, clen);
        default: count = ntiles + $urandom_range(2, 0);           // ends on length
      endcase

      add_word(CMPT_MAGIC);
      add_word(CMPT_VERSION);
      add_word(clen);
      add_word(count);
      for (int i = 0; i < ntiles; i++) begin
        add_word($urandom);     // inner magic
        add_word($urandom);     // inner version, not checked
        add_word(lens[i]);
        repeat (bodies[i]) stream_bytes.insert(stream_bytes.size(), 8'($urandom));
      end
      repeat ($urandom_range(3, 0)) stream_bytes.insert(stream_bytes.size(), 8'($urandom));

      if (flavor == 6)           // corrupt magic or version
        stream_bytes[$urandom_range(7, 0)] ^= 8'($urandom_range(255, 1));
      if (flavor == 5 && stream_bytes.size() > 1) begin   // buffer ends early
        cut = $urandom_range(stream_bytes.size() - 1, 1);
        while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
      end
    end
  endtask

  // Only the first byte's size is sampled; later ones get noise.
  task automatic send_stream(bit quiet);
    foreach (stream_bytes[i])
      send_byte(stream_bytes[i], (i == stream_bytes.size() - 1),
                (i == 0) ? stream_size : 32'($urandom),
                quiet ? 0 : pick_gap(), 1'b0, EV_TILE);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned base_bytes;
    bit          burst_done;
    bit          quiet;

    rst_n               <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.data_byte     <= '0;
    in_if.end_of_buffer <= 1'b0;
    in_if.buffer_size   <= '0;
    pin_on              <= 1'b0;
    pin_ev              <= EV_TILE;
    hold_request = 1'b0;
    steady_sink  = 1'b0;
    failures     = 0;
    live_bytes   = 0;
    sent_bytes   = 0;
    buffers_seen = 0;
    records_checked = 0;
    input_stalls = 0;
    foreach (ev_count[i]) ev_count[i] = 0;
    burst_done   = 1'b0;
    parse_reset();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Scripted header cases
    foreach (script_rows[i])
      send_byte(script_rows[i].data, script_rows[i].eob, script_rows[i].size,
                pick_gap(), script_rows[i].pinned, script_rows[i].ev);
    wait_for_results();

    // Random containers
    base_bytes = sent_bytes;
    while (sent_bytes - base_bytes < RANDOM_BYTES) begin
      if (!burst_done && sent_bytes - base_bytes > RANDOM_BYTES / 2) begin
        // Output held off while short buffers keep coming: the result queue
        // fills and in_chan.ready must drop until the sink lets go.
        wait_for_results();
        hold_request = 1'b1;
        wait (!hold_request);
        repeat (24)
          send_byte(8'($urandom), 1'b1, 32'($urandom_range(15, 0)), 0, 1'b1, EV_SHORT);
        wait_for_results();
        burst_done = 1'b1;
      end
      quiet = ($urandom_range(3, 0) == 0);
      steady_sink = quiet;
      build_stream();
      send_stream(quiet);
      if ($urandom_range(9, 0) == 0)
        wait_for_results();
    end

    steady_sink = 1'b0;
    wait_for_results();
    repeat (20) @(posedge clk);   // catch any stray result
    if (expected_records.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_records.size()));

    $display("Covered %0d bytes (%0d parsed) in %0d buffers, %0d results checked, %0d input stalls",
             sent_bytes, live_bytes, buffers_seen, records_checked, input_stalls);
    $display("Results by status: tile %0d short %0d magic %0d version %0d over %0d trunc %0d done %0d",
             ev_count[0], ev_count[1], ev_count[2], ev_count[3], ev_count[4],
             ev_count[5], ev_count[6]);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d failures", failures);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
